>>> rtl/slng_pkg.sv
package slng_pkg;

   localparam int COORD_BITS_DEFAULT = 10;
   localparam int CFG_BITS = 11;
   localparam int ORDER_BITS = 11;
   localparam int CSR_INDEX_BITS = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int PAIRS_PER_SITE = 4;
   localparam int LAST_BITS = $clog2(PAIRS_PER_SITE);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_ORDER  = 3'd2,
      CSR_WRAP   = 3'd3,
      CSR_MODE   = 3'd4
   } csr_index_type;

   // per-site control that rides along the pipeline
   typedef struct packed {
      logic valid;
      logic even;
      logic wrap;
      logic nbr_list;
   } ctl_type;

   // which offsets stay on the lattice, plus the error condition
   typedef struct packed {
      logic xpo;
      logic xmo;
      logic ypo;
      logic ymo;
      logic err;
   } reach_type;

   typedef struct packed {
      logic                 push;
      logic                 drop;
      logic                 err;
      logic [LAST_BITS-1:0] last_idx;
   } bundle_ctl_type;

   // even order: nbr/2, odd order: (nbr+1)/2
   function automatic logic [ORDER_BITS-1:0] order_distance(
      input logic [ORDER_BITS-1:0] nbr);
      return {1'b0, nbr[ORDER_BITS-1:1]} + {{(ORDER_BITS-1){1'b0}}, nbr[0]};
   endfunction

endpackage

>>> rtl/slng_offset.sv
module slng_offset import slng_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               in_ctl,
   input  logic [COORD_BITS-1:0] in_x,
   input  logic [COORD_BITS-1:0] in_y,
   input  logic [COORD_BITS:0]   in_w,
   input  logic [COORD_BITS:0]   in_h,
   input  logic [ORDER_BITS-1:0] in_k,
   output ctl_type               out_ctl,
   output reach_type             out_reach,
   output logic [COORD_BITS-1:0] out_x,
   output logic [COORD_BITS-1:0] out_y,
   output logic [COORD_BITS-1:0] out_xp,
   output logic [COORD_BITS-1:0] out_xm,
   output logic [COORD_BITS-1:0] out_yp,
   output logic [COORD_BITS-1:0] out_ym
);

   localparam int SIDE_W = COORD_BITS + 1;
   localparam int SUM_W  = ((SIDE_W > ORDER_BITS) ? SIDE_W : ORDER_BITS) + 1;

   // stage a: captured site and configuration
   ctl_type               a_ctl_ff;
   logic [COORD_BITS-1:0] a_x_ff, a_y_ff;
   logic [SIDE_W-1:0]     a_w_ff, a_h_ff;
   logic [ORDER_BITS-1:0] a_k_ff;

   // stage b: raw sums and differences
   ctl_type               b_ctl_ff;
   logic [COORD_BITS-1:0] b_x_ff, b_y_ff;
   logic [SIDE_W-1:0]     b_w_ff, b_h_ff;
   logic [ORDER_BITS-1:0] b_k_ff;
   logic [SUM_W-1:0]      b_tx_ff, b_ty_ff, b_dx_ff, b_dy_ff, b_xw_ff, b_yh_ff;
   logic                  b_gex_ff, b_gey_ff, b_err_ff;
   logic [SUM_W-1:0]      b_tx_in, b_ty_in, b_dx_in, b_dy_in, b_xw_in, b_yh_in;
   logic                  b_gex_in, b_gey_in, b_err_in;

   // stage c: wrapped coordinates
   ctl_type               c_ctl_ff;
   reach_type             c_reach_ff, c_reach_in;
   logic [COORD_BITS-1:0] c_x_ff, c_y_ff;
   logic [COORD_BITS-1:0] c_xp_ff, c_xm_ff, c_yp_ff, c_ym_ff;
   logic [COORD_BITS-1:0] c_xp_in, c_xm_in, c_yp_in, c_ym_in;
   logic [SUM_W-1:0]      xp_sub, xm_sub, yp_sub, ym_sub;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= in_ctl;
         b_ctl_ff <= a_ctl_ff;
         c_ctl_ff <= b_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_x_ff <= in_x;
      a_y_ff <= in_y;
      a_w_ff <= in_w;
      a_h_ff <= in_h;
      a_k_ff <= in_k;
   end

   assign b_tx_in  = SUM_W'(a_x_ff) + SUM_W'(a_k_ff);
   assign b_ty_in  = SUM_W'(a_y_ff) + SUM_W'(a_k_ff);
   assign b_dx_in  = SUM_W'(a_x_ff) - SUM_W'(a_k_ff);
   assign b_dy_in  = SUM_W'(a_y_ff) - SUM_W'(a_k_ff);
   assign b_xw_in  = SUM_W'(a_x_ff) + SUM_W'(a_w_ff);
   assign b_yh_in  = SUM_W'(a_y_ff) + SUM_W'(a_h_ff);
   assign b_gex_in = SUM_W'(a_x_ff) >= SUM_W'(a_k_ff);
   assign b_gey_in = SUM_W'(a_y_ff) >= SUM_W'(a_k_ff);
   assign b_err_in = (SIDE_W'(a_x_ff) >= a_w_ff) || (SIDE_W'(a_y_ff) >= a_h_ff)
                  || (a_ctl_ff.wrap && ((SUM_W'(a_k_ff) > SUM_W'(a_w_ff))
                                     || (SUM_W'(a_k_ff) > SUM_W'(a_h_ff))));

   always_ff @(posedge clock) begin
      b_x_ff   <= a_x_ff;
      b_y_ff   <= a_y_ff;
      b_w_ff   <= a_w_ff;
      b_h_ff   <= a_h_ff;
      b_k_ff   <= a_k_ff;
      b_tx_ff  <= b_tx_in;
      b_ty_ff  <= b_ty_in;
      b_dx_ff  <= b_dx_in;
      b_dy_ff  <= b_dy_in;
      b_xw_ff  <= b_xw_in;
      b_yh_ff  <= b_yh_in;
      b_gex_ff <= b_gex_in;
      b_gey_ff <= b_gey_in;
      b_err_ff <= b_err_in;
   end

   // the wrapped value equals the plain one whenever the offset stays on the lattice
   assign xp_sub = b_tx_ff - SUM_W'(b_w_ff);
   assign yp_sub = b_ty_ff - SUM_W'(b_h_ff);
   assign xm_sub = b_xw_ff - SUM_W'(b_k_ff);
   assign ym_sub = b_yh_ff - SUM_W'(b_k_ff);

   assign c_reach_in.xpo = b_tx_ff < SUM_W'(b_w_ff);
   assign c_reach_in.ypo = b_ty_ff < SUM_W'(b_h_ff);
   assign c_reach_in.xmo = b_gex_ff;
   assign c_reach_in.ymo = b_gey_ff;
   assign c_reach_in.err = b_err_ff;

   assign c_xp_in = c_reach_in.xpo ? b_tx_ff[COORD_BITS-1:0] : xp_sub[COORD_BITS-1:0];
   assign c_yp_in = c_reach_in.ypo ? b_ty_ff[COORD_BITS-1:0] : yp_sub[COORD_BITS-1:0];
   assign c_xm_in = b_gex_ff ? b_dx_ff[COORD_BITS-1:0] : xm_sub[COORD_BITS-1:0];
   assign c_ym_in = b_gey_ff ? b_dy_ff[COORD_BITS-1:0] : ym_sub[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      c_reach_ff <= c_reach_in;
      c_x_ff     <= b_x_ff;
      c_y_ff     <= b_y_ff;
      c_xp_ff    <= c_xp_in;
      c_xm_ff    <= c_xm_in;
      c_yp_ff    <= c_yp_in;
      c_ym_ff    <= c_ym_in;
   end

   assign out_ctl   = c_ctl_ff;
   assign out_reach = c_reach_ff;
   assign out_x     = c_x_ff;
   assign out_y     = c_y_ff;
   assign out_xp    = c_xp_ff;
   assign out_xm    = c_xm_ff;
   assign out_yp    = c_yp_ff;
   assign out_ym    = c_ym_ff;

endmodule

>>> rtl/slng_select.sv
module slng_select import slng_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  ctl_type                                  in_ctl,
   input  reach_type                                in_reach,
   input  logic [COORD_BITS-1:0]                    in_x,
   input  logic [COORD_BITS-1:0]                    in_y,
   input  logic [COORD_BITS-1:0]                    in_xp,
   input  logic [COORD_BITS-1:0]                    in_xm,
   input  logic [COORD_BITS-1:0]                    in_yp,
   input  logic [COORD_BITS-1:0]                    in_ym,
   output bundle_ctl_type                           out_ctl,
   output logic [PAIRS_PER_SITE-1:0][4*COORD_BITS-1:0] out_pairs
);

   localparam int PAIR_W = 4 * COORD_BITS;
   localparam int CNT_W  = $clog2(PAIRS_PER_SITE + 1);

   logic [PAIRS_PER_SITE-1:0][PAIR_W-1:0] cand;
   logic [PAIRS_PER_SITE-1:0]             cand_ok;
   logic [PAIRS_PER_SITE-1:0][PAIR_W-1:0] pairs_in, pairs_ff;
   logic [CNT_W-1:0]                      count_in, count_m1;
   logic                                  valid_ff;
   logic                                  any_ff;
   logic                                  err_ff;
   logic [LAST_BITS-1:0]                  last_ff;
   logic [COORD_BITS-1:0]                 zero_c;

   assign zero_c = '0;

   // candidate pairs in emission order, each word is {from_x, from_y, to_x, to_y}
   always_comb begin
      cand    = '0;
      cand_ok = '0;
      if (in_reach.err) begin
         cand[0] = {in_x, in_y, zero_c, zero_c};
         cand_ok = 4'b0001;
      end else if (in_ctl.nbr_list) begin
         if (in_ctl.even) begin
            cand[0] = {in_x, in_y, in_xp, in_yp};
            cand[1] = {in_x, in_y, in_xm, in_yp};
            cand[2] = {in_x, in_y, in_xp, in_ym};
            cand[3] = {in_x, in_y, in_xm, in_ym};
            cand_ok = in_ctl.wrap ? 4'b1111
                    : {in_reach.xmo & in_reach.ymo, in_reach.xpo & in_reach.ymo,
                       in_reach.xmo & in_reach.ypo, in_reach.xpo & in_reach.ypo};
         end else begin
            cand[0] = {in_x, in_y, in_xp, in_y};
            cand[1] = {in_x, in_y, in_xm, in_y};
            cand[2] = {in_x, in_y, in_x, in_yp};
            cand[3] = {in_x, in_y, in_x, in_ym};
            cand_ok = in_ctl.wrap ? 4'b1111
                    : {in_reach.ymo, in_reach.ypo, in_reach.xmo, in_reach.xpo};
         end
      end else if (in_ctl.even) begin
         cand[0] = {in_x, in_y, in_xp, in_yp};
         cand[1] = {in_x, in_yp, in_xp, in_y};
         cand_ok = (in_ctl.wrap || (in_reach.xpo && in_reach.ypo)) ? 4'b0011 : 4'b0000;
      end else if (in_ctl.wrap) begin
         cand[0] = {in_x, in_y, in_xp, in_y};
         cand[1] = {in_x, in_y, in_x, in_yp};
         cand_ok = 4'b0011;
      end else begin
         // open bonds: the y bond comes first
         cand[0] = {in_x, in_y, in_x, in_yp};
         cand[1] = {in_x, in_y, in_xp, in_y};
         cand_ok = {2'b00, in_reach.xpo, in_reach.ypo};
      end
   end

   // pack the surviving pairs to the front
   always_comb begin
      logic [CNT_W-1:0] n;
      n        = '0;
      pairs_in = '0;
      for (int i = 0; i < PAIRS_PER_SITE; i++) begin
         if (cand_ok[i]) begin
            pairs_in[n[LAST_BITS-1:0]] = cand[i];
            n = n + CNT_W'(1);
         end
      end
      count_in = n;
   end

   assign count_m1 = count_in - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      pairs_ff <= pairs_in;
      any_ff   <= count_in != '0;
      err_ff   <= in_reach.err;
      last_ff  <= count_m1[LAST_BITS-1:0];
   end

   assign out_ctl.push     = valid_ff && any_ff;
   assign out_ctl.drop     = valid_ff && !any_ff;
   assign out_ctl.err      = err_ff;
   assign out_ctl.last_idx = last_ff;
   assign out_pairs        = pairs_ff;

endmodule

>>> rtl/slng_emit.sv
module slng_emit import slng_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  bundle_ctl_type                               in_ctl,
   input  logic [PAIRS_PER_SITE-1:0][4*COORD_BITS-1:0] in_pairs,
   output logic                                         pop,
   output logic                                         rsp_valid,
   output logic [COORD_BITS-1:0]                        rsp_from_x,
   output logic [COORD_BITS-1:0]                        rsp_from_y,
   output logic [COORD_BITS-1:0]                        rsp_to_x,
   output logic [COORD_BITS-1:0]                        rsp_to_y,
   output logic                                         rsp_last_pair,
   output logic                                         rsp_error_flag
);

   localparam int PAIR_W = 4 * COORD_BITS;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [PAIRS_PER_SITE-1:0][PAIR_W-1:0] q_pairs_ff [QUEUE_DEPTH];
   logic [LAST_BITS-1:0]                  q_last_ff  [QUEUE_DEPTH];
   logic                                  q_err_ff   [QUEUE_DEPTH];

   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [LAST_BITS-1:0] sel_ff, sel_in;
   logic                 have;
   logic [PAIR_W-1:0]    head_pair;
   logic [LAST_BITS-1:0] head_last;
   logic                 head_err;

   logic                  valid_ff;
   logic [PAIR_W-1:0]     pair_ff;
   logic                  last_ff;
   logic                  err_ff;

   assign have      = fill_ff != '0;
   assign head_pair = q_pairs_ff[rd_ptr_ff][sel_ff];
   assign head_last = q_last_ff[rd_ptr_ff];
   assign head_err  = q_err_ff[rd_ptr_ff];
   assign pop       = have && (sel_ff == head_last);

   assign wr_ptr_in = in_ctl.push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign fill_in   = fill_ff + FILL_W'(in_ctl.push) - FILL_W'(pop);
   assign sel_in    = pop ? '0 : (have ? sel_ff + LAST_BITS'(1) : sel_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         sel_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         sel_ff    <= sel_in;
         valid_ff  <= have;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.push) begin
         q_pairs_ff[wr_ptr_ff] <= in_pairs;
         q_last_ff[wr_ptr_ff]  <= in_ctl.last_idx;
         q_err_ff[wr_ptr_ff]   <= in_ctl.err;
      end
   end

   // one word per cycle from the head entry while the queue is not empty
   always_ff @(posedge clock) begin
      pair_ff <= head_pair;
      last_ff <= pop;
      err_ff  <= head_err;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_from_x     = pair_ff[4*COORD_BITS-1:3*COORD_BITS];
   assign rsp_from_y     = pair_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign rsp_to_x       = pair_ff[2*COORD_BITS-1:COORD_BITS];
   assign rsp_to_y       = pair_ff[COORD_BITS-1:0];
   assign rsp_last_pair  = last_ff;
   assign rsp_error_flag = err_ff;

endmodule

>>> rtl/square_lattice_neighbor_generator_unit.sv
// the first word of a site passes offset stages a, b and c, the select register,
// the result queue and the output register; the rest of its words follow one per cycle
// throughput: one word per cycle on the single result port; a site yields up to
// 4 words, and a site with no word is dropped before the result queue
// up to 8 sites may be in flight; busy rises while all 8 result slots are held
// reset is synchronous: registers return to their defaults, pipeline and queue empty
module square_lattice_neighbor_generator_unit import slng_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [COORD_BITS-1:0]     req_site_x,
   input  logic [COORD_BITS-1:0]     req_site_y,
   output logic                      rsp_valid,
   output logic [COORD_BITS-1:0]     rsp_from_x,
   output logic [COORD_BITS-1:0]     rsp_from_y,
   output logic [COORD_BITS-1:0]     rsp_to_x,
   output logic [COORD_BITS-1:0]     rsp_to_y,
   output logic                      rsp_last_pair,
   output logic                      rsp_error_flag,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   localparam int SIDE_W = COORD_BITS + 1;
   localparam int OUT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [SIDE_W-1:0] SIDE_CAP = {1'b1, {COORD_BITS{1'b0}}};

   logic [CFG_BITS-1:0]   width_ff, height_ff;
   logic [ORDER_BITS-1:0] order_ff;
   logic                  wrap_ff, mode_ff;

   logic [SIDE_W-1:0]     side_w_raw, side_h_raw, side_w, side_h;
   logic                  accept;
   ctl_type               in_ctl;
   logic [OUT_W-1:0]      outstanding_ff, outstanding_in;

   ctl_type               c_ctl;
   reach_type             c_reach;
   logic [COORD_BITS-1:0] c_x, c_y, c_xp, c_xm, c_yp, c_ym;
   bundle_ctl_type        d_ctl;
   logic [PAIRS_PER_SITE-1:0][4*COORD_BITS-1:0] d_pairs;
   logic                  pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_BITS'(1);
         height_ff <= CFG_BITS'(1);
         order_ff  <= ORDER_BITS'(1);
         wrap_ff   <= 1'b0;
         mode_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_ORDER:  order_ff  <= csr_wdata[ORDER_BITS-1:0];
            CSR_WRAP:   wrap_ff   <= csr_wdata[0];
            CSR_MODE:   mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sides are clipped to the coordinate range
   assign side_w_raw = SIDE_W'(width_ff);
   assign side_h_raw = SIDE_W'(height_ff);
   assign side_w     = (side_w_raw > SIDE_CAP) ? SIDE_CAP : side_w_raw;
   assign side_h     = (side_h_raw > SIDE_CAP) ? SIDE_CAP : side_h_raw;

   // each site holds a slot from acceptance until its last word leaves the queue, or until it is dropped with no word
   assign busy   = outstanding_ff == OUT_W'(QUEUE_DEPTH);
   assign accept = start && !busy;

   assign in_ctl.valid    = accept;
   assign in_ctl.even     = !order_ff[0];
   assign in_ctl.wrap     = wrap_ff;
   assign in_ctl.nbr_list = mode_ff;

   assign outstanding_in = outstanding_ff + OUT_W'(accept) - OUT_W'(pop)
                         - OUT_W'(d_ctl.drop);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   slng_offset #(
      .COORD_BITS(COORD_BITS)
   ) u_offset (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (in_ctl),
      .in_x      (req_site_x),
      .in_y      (req_site_y),
      .in_w      (side_w),
      .in_h      (side_h),
      .in_k      (order_distance(order_ff)),
      .out_ctl   (c_ctl),
      .out_reach (c_reach),
      .out_x     (c_x),
      .out_y     (c_y),
      .out_xp    (c_xp),
      .out_xm    (c_xm),
      .out_yp    (c_yp),
      .out_ym    (c_ym)
   );

   slng_select #(
      .COORD_BITS(COORD_BITS)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (c_ctl),
      .in_reach  (c_reach),
      .in_x      (c_x),
      .in_y      (c_y),
      .in_xp     (c_xp),
      .in_xm     (c_xm),
      .in_yp     (c_yp),
      .in_ym     (c_ym),
      .out_ctl   (d_ctl),
      .out_pairs (d_pairs)
   );

   slng_emit #(
      .COORD_BITS(COORD_BITS)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .in_ctl         (d_ctl),
      .in_pairs       (d_pairs),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_from_x     (rsp_from_x),
      .rsp_from_y     (rsp_from_y),
      .rsp_to_x       (rsp_to_x),
      .rsp_to_y       (rsp_to_y),
      .rsp_last_pair  (rsp_last_pair),
      .rsp_error_flag (rsp_error_flag)
   );

   a_slots_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OUT_W'(QUEUE_DEPTH))
      else $error("more sites in flight than result slots");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_last_pair)
      else $error("error word not marked as last");

   a_slot_taken: assert property (@(posedge clock) disable iff (reset)
      accept && !pop && !d_ctl.drop |=> outstanding_ff == $past(outstanding_ff) + OUT_W'(1))
      else $error("accepted site did not take a slot");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import slng_pkg::*;

   localparam int CB = COORD_BITS_DEFAULT;
   localparam int NUM_PHASES = 8;
   localparam int SITES_PER_PHASE = 40;
   localparam int SETTLE_CYCLES = 16;
   localparam int IDLE_LIMIT = 1000;

   typedef struct packed {
      logic [CB-1:0] from_x;
      logic [CB-1:0] from_y;
      logic [CB-1:0] to_x;
      logic [CB-1:0] to_y;
      logic          last_pair;
      logic          error_flag;
   } pair_word_type;

   typedef enum {ROW_PREDICT, ROW_ERROR, ROW_NONE} row_kind_type;

   typedef struct {
      int           w;
      int           h;
      int           nbr;
      int           wrap;
      int           mode;
      int           x;
      int           y;
      row_kind_type kind;
   } site_row_type;

   // lattice setup, then one site; error and empty rows carry their answer
   site_row_type directed_rows[25] = '{
      '{1, 1, 1, 0, 1, 0, 0, ROW_NONE},
      '{1, 1, 1, 0, 1, 1023, 1023, ROW_ERROR},
      '{1024, 1024, 1, 0, 1, 0, 0, ROW_PREDICT},
      '{1024, 1024, 1, 0, 1, 1023, 1023, ROW_PREDICT},
      '{1024, 1024, 1, 0, 1, 512, 300, ROW_PREDICT},
      '{1024, 1024, 2, 0, 1, 5, 5, ROW_PREDICT},
      '{1024, 1024, 2, 0, 0, 5, 5, ROW_PREDICT},
      '{1024, 1024, 1, 0, 0, 1023, 1022, ROW_PREDICT},
      '{1024, 1024, 1, 1, 1, 1023, 0, ROW_PREDICT},
      '{1024, 1024, 2, 1, 1, 0, 1023, ROW_PREDICT},
      '{1024, 1024, 3, 1, 0, 10, 20, ROW_PREDICT},
      '{1024, 1024, 4, 1, 0, 1023, 1023, ROW_PREDICT},
      '{5, 7, 2047, 1, 1, 2, 3, ROW_ERROR},
      '{1024, 3, 7, 1, 1, 1, 1, ROW_ERROR},
      '{5, 7, 10, 1, 1, 2, 3, ROW_PREDICT},
      '{8, 8, 0, 0, 1, 3, 3, ROW_PREDICT},
      '{8, 8, 0, 1, 0, 0, 0, ROW_PREDICT},
      '{0, 8, 1, 0, 1, 0, 0, ROW_ERROR},
      '{8, 0, 1, 0, 1, 0, 0, ROW_ERROR},
      '{2047, 2047, 1, 0, 1, 1023, 1023, ROW_PREDICT},
      '{2047, 1025, 2047, 1, 1, 1023, 5, ROW_PREDICT},
      '{1024, 1024, 2047, 0, 1, 0, 0, ROW_NONE},
      '{1, 1, 1, 1, 1, 0, 0, ROW_PREDICT},
      '{1024, 1, 1, 0, 0, 1023, 0, ROW_PREDICT},
      '{1024, 1024, 6, 0, 0, 1021, 1021, ROW_PREDICT}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [CB-1:0]             req_site_x = '0;
   logic [CB-1:0]             req_site_y = '0;
   logic                      rsp_valid;
   logic [CB-1:0]             rsp_from_x;
   logic [CB-1:0]             rsp_from_y;
   logic [CB-1:0]             rsp_to_x;
   logic [CB-1:0]             rsp_to_y;
   logic                      rsp_last_pair;
   logic                      rsp_error_flag;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_WIDTH;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   pair_word_type pending_pairs[$];
   pair_word_type got_word;
   pair_word_type want_word;
   int            fail_count = 0;
   int            idle_cycles = 0;
   bit            gap_on = 1'b1;

   // lattice setup as the block should hold it, reset values first
   int cfg_width = 1;
   int cfg_height = 1;
   int cfg_order = 1;
   int cfg_wrap = 0;
   int cfg_mode = 1;

   square_lattice_neighbor_generator_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_site_x     (req_site_x),
      .req_site_y     (req_site_y),
      .rsp_valid      (rsp_valid),
      .rsp_from_x     (rsp_from_x),
      .rsp_from_y     (rsp_from_y),
      .rsp_to_x       (rsp_to_x),
      .rsp_to_y       (rsp_to_y),
      .rsp_last_pair  (rsp_last_pair),
      .rsp_error_flag (rsp_error_flag),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int side_of(input int v);
      int s;
      s = v & 'h7FF;
      return (s > (1 << CB)) ? (1 << CB) : s;
   endfunction

   task automatic add_pair(input int fx, input int fy, input int tx, input int ty);
      pair_word_type word;
      word.from_x = CB'(fx);
      word.from_y = CB'(fy);
      word.to_x = CB'(tx);
      word.to_y = CB'(ty);
      word.last_pair = 1'b0;
      word.error_flag = 1'b0;
      pending_pairs = {pending_pairs, word};
   endtask

   // expected words of one site under the current lattice setup
   task automatic predict_site(input int x, input int y);
      int            w, h, k, xp, xm, yp, ym, base;
      bit            even, xpo, xmo, ypo, ymo;
      pair_word_type word;
      w = side_of(cfg_width);
      h = side_of(cfg_height);
      even = (cfg_order % 2) == 0;
      k = even ? cfg_order / 2 : (cfg_order + 1) / 2;
      base = pending_pairs.size();
      if (x >= w || y >= h || (cfg_wrap != 0 && (k > w || k > h))) begin
         add_pair(x, y, 0, 0);
         word = pending_pairs.pop_back();
         word.error_flag = 1'b1;
         word.last_pair = 1'b1;
         pending_pairs = {pending_pairs, word};
         return;
      end
      if (cfg_wrap != 0) begin
         xp = (x + k) % w;
         xm = (x - k + w) % w;
         yp = (y + k) % h;
         ym = (y - k + h) % h;
         if (cfg_mode != 0) begin
            if (even) begin
               add_pair(x, y, xp, yp);
               add_pair(x, y, xm, yp);
               add_pair(x, y, xp, ym);
               add_pair(x, y, xm, ym);
            end else begin
               add_pair(x, y, xp, y);
               add_pair(x, y, xm, y);
               add_pair(x, y, x, yp);
               add_pair(x, y, x, ym);
            end
         end else if (even) begin
            add_pair(x, y, xp, yp);
            add_pair(x, yp, xp, y);
         end else begin
            add_pair(x, y, xp, y);
            add_pair(x, y, x, yp);
         end
      end else begin
         xpo = x + k < w;
         xmo = x >= k;
         ypo = y + k < h;
         ymo = y >= k;
         if (cfg_mode != 0) begin
            if (even) begin
               if (xpo && ypo) add_pair(x, y, x + k, y + k);
               if (xmo && ypo) add_pair(x, y, x - k, y + k);
               if (xpo && ymo) add_pair(x, y, x + k, y - k);
               if (xmo && ymo) add_pair(x, y, x - k, y - k);
            end else begin
               if (xpo) add_pair(x, y, x + k, y);
               if (xmo) add_pair(x, y, x - k, y);
               if (ypo) add_pair(x, y, x, y + k);
               if (ymo) add_pair(x, y, x, y - k);
            end
         end else if (even) begin
            // bond anchored at the lower corner of its box
            if (xpo && ypo) begin
               add_pair(x, y, x + k, y + k);
               add_pair(x, y + k, x + k, y);
            end
         end else begin
            if (ypo) add_pair(x, y, x, y + k);
            if (xpo) add_pair(x, y, x + k, y);
         end
      end
      if (pending_pairs.size() > base) begin
         word = pending_pairs.pop_back();
         word.last_pair = 1'b1;
         pending_pairs = {pending_pairs, word};
      end
   endtask

   task automatic send_site(input int x, input int y);
      int gap;
      gap = gap_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_site_x <= CB'(x);
      req_site_y <= CB'(y);
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // sites may produce no word, so give the pipeline time to empty
   task automatic drain_results();
      start <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input int w, input int h, input int nbr, input int wrap,
                               input int mode);
      csr_index_type idx;
      drain_results();
      cfg_width = w;
      cfg_height = h;
      cfg_order = nbr;
      cfg_wrap = wrap;
      cfg_mode = mode;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_we <= 1'b1;
         csr_index <= idx;
         case (idx)
            CSR_WIDTH:  csr_wdata <= CFG_BITS'(w);
            CSR_HEIGHT: csr_wdata <= CFG_BITS'(h);
            CSR_ORDER:  csr_wdata <= CFG_BITS'(nbr);
            CSR_WRAP:   csr_wdata <= CFG_BITS'(wrap);
            default:    csr_wdata <= CFG_BITS'(mode);
         endcase
         @(posedge clock);
         idx = idx.next();
      end
      csr_we <= 1'b0;
   endtask

   function automatic int pick_side();
      case ($urandom_range(0, 9))
         0:       return 1024;
         1:       return $urandom_range(1025, 2047);
         2:       return $urandom_range(1, 1024);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   function automatic int pick_order();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(1, 2047);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic int pick_coord(input int side);
      if (side == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, (1 << CB) - 1);
      return $urandom_range(0, side - 1);
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid) begin
            got_word = '{rsp_from_x, rsp_from_y, rsp_to_x, rsp_to_y, rsp_last_pair,
                         rsp_error_flag};
            if (pending_pairs.size() == 0) begin
               $error("word with nothing pending: from (%0d,%0d) to (%0d,%0d)",
                      got_word.from_x, got_word.from_y, got_word.to_x, got_word.to_y);
               fail_count++;
            end else begin
               want_word = pending_pairs.pop_front();
               check_field("from_x", want_word.from_x, got_word.from_x);
               check_field("from_y", want_word.from_y, got_word.from_y);
               check_field("to_x", want_word.to_x, got_word.to_x);
               check_field("to_y", want_word.to_y, got_word.to_y);
               check_field("last_pair", want_word.last_pair, got_word.last_pair);
               check_field("error_flag", want_word.error_flag, got_word.error_flag);
            end
         end
         if (rsp_valid || (start && !busy)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   initial begin
      site_row_type  row;
      pair_word_type err_word;
      int            w, h, x, y;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.w != cfg_width || row.h != cfg_height || row.nbr != cfg_order ||
             row.wrap != cfg_wrap || row.mode != cfg_mode) begin
            apply_config(row.w, row.h, row.nbr, row.wrap, row.mode);
         end
         send_site(row.x, row.y);
         case (row.kind)
            ROW_PREDICT: predict_site(row.x, row.y);
            ROW_ERROR: begin
               err_word = '{CB'(row.x), CB'(row.y), '0, '0, 1'b1, 1'b1};
               pending_pairs = {pending_pairs, err_word};
            end
            default: ;
         endcase
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // first two phases pin the largest and the smallest lattice
         w = (p == 0) ? 1024 : (p == 1) ? 1 : pick_side();
         h = (p == 0) ? 1024 : (p == 1) ? 1 : pick_side();
         apply_config(w, h, pick_order(), $urandom_range(0, 1), $urandom_range(0, 1));
         gap_on = (p % 2) == 0;
         for (int i = 0; i < SITES_PER_PHASE; i++) begin
            if ($urandom_range(0, 63) == 0) drain_results();
            x = pick_coord(side_of(cfg_width));
            y = pick_coord(side_of(cfg_height));
            send_site(x, y);
            predict_site(x, y);
         end
      end

      drain_results();
      if (fail_count == 0 && pending_pairs.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> square_lattice_neighbor_generator_unit.f
rtl/slng_pkg.sv
rtl/slng_offset.sv
rtl/slng_select.sv
rtl/slng_emit.sv
rtl/square_lattice_neighbor_generator_unit.sv
tb/tb_top.sv
